// ===== design/fpfa_pkg.sv =====
// Shared types, constants and helper functions for the fixed-partition fit allocator.
package fpfa_pkg;

  localparam int NUM_BLOCKS_DEF = 8;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int FUNC_W       = 2;
  localparam int IDX_FIELD_W  = 3;
  localparam int SIZE_FIELD_W = 16;
  localparam int SUM_W        = 19;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 48;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    FN_REQUEST = 2'd0,
    FN_LOAD    = 2'd1,
    FN_CLEAR   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_GRANT,
    ST_LD_RD,
    ST_LD_SUB,
    ST_LD_ADD,
    ST_FINISH
  } state_t;

  // Strobes from the sequencer to the scan unit
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] sat_sub(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    return (a >= b) ? (a - b) : '0;
  endfunction

endpackage

// ===== design/fpfa_size_ram.sv =====
// Partition size store: one write port, one read port with registered data.
module fpfa_size_ram #(
  parameter int DEPTH = fpfa_pkg::NUM_BLOCKS_DEF,
  parameter int WIDTH = fpfa_pkg::SIZE_BITS_DEF,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/fpfa_scan_unit.sv =====
// Shared compare unit: checks one partition per step and tracks the current pick.
module fpfa_scan_unit #(
  parameter int SIZE_BITS = fpfa_pkg::SIZE_BITS_DEF,
  parameter int IDX_W     = 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fpfa_pkg::scan_ctl_t     ctl_i,
  input  fpfa_pkg::policy_t       policy_i,
  input  logic [SIZE_BITS-1:0]    req_i,
  input  logic [SIZE_BITS-1:0]    size_i,
  input  logic                    elig_i,
  input  logic [IDX_W-1:0]        idx_i,
  output logic                    found_o,
  output logic [IDX_W-1:0]        pick_o
);
  import fpfa_pkg::*;

  logic                 have_r;
  logic [IDX_W-1:0]     pick_r;
  logic [SIZE_BITS-1:0] best_r;
  logic                 fits;
  logic                 better;
  logic                 take;

  always_comb begin
    fits = elig_i && (size_i >= req_i);
    case (policy_i)
      POL_BEST:  better = size_i < best_r;
      POL_WORST: better = size_i > best_r;
      default:   better = 1'b0;
    endcase
    take = fits && (!have_r || better);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (ctl_i.clear) begin
      have_r <= 1'b0;
    end else if (ctl_i.step && take) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.step && take) begin
      pick_r <= idx_i;
      best_r <= size_i;
    end
  end

  assign found_o = have_r;
  assign pick_o  = pick_r;

endmodule

// ===== design/fixed_partition_fit_allocator.sv =====
// Top level of the fixed-partition fit allocator: sequencer, flags, totals, result register.
// A request scans the size store, which reads one partition size per cycle, then passes
// through the wait and grant states. A load reads the old size, subtracts it, adds the new
// size and writes it; a clear or an unused code goes straight to the finish state.
// Throughput: one item at a time; in_tready is high only while the sequencer is idle, and
// a finished result waits in the output register while the next item is accepted.
// Reset (rst_n low, synchronous) empties the table flags, pointer, totals and policy.
module fixed_partition_fit_allocator #(
  parameter int NUM_BLOCKS = fpfa_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration: fit policy
  input  logic                             cfg_wr_en,
  input  logic [1:0]                       cfg_wr_data,
  // input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: block_index [2:0], size [18:3], zero fill above
  input  logic [fpfa_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: func [1:0]
  input  logic [fpfa_pkg::FUNC_W-1:0]      in_tuser,
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: granted [0], block_number [3:1], allocated_total [22:4],
  //        total_memory [41:23], zero fill above
  output logic [fpfa_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import fpfa_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  state_t                  state_r, state_nxt;
  logic [IDX_FIELD_W-1:0]  idx_r;
  logic [SIZE_BITS-1:0]    req_r;
  policy_t                 policy_r;
  logic [NUM_BLOCKS-1:0]   loaded_r;
  logic [NUM_BLOCKS-1:0]   taken_r;
  logic [IDX_W-1:0]        ptr_r;
  logic [SUM_W-1:0]        granted_sum_r;
  logic [SUM_W-1:0]        memory_sum_r;
  logic [IDX_W-1:0]        scan_addr_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [IDX_W-1:0]        rd_idx_r;
  logic                    rd_vld_r;
  logic                    granted_r;
  logic [IDX_FIELD_W-1:0]  number_r;
  logic                    out_valid_r;
  logic [OUT_TDATA_W-1:0]  out_data_r;

  logic                    in_xfer;
  logic                    out_free;
  logic [IDX_W-1:0]        ld_addr;
  logic [IDX_W-1:0]        rd_addr;
  logic [SIZE_BITS-1:0]    rd_data;
  logic                    ram_wr;
  scan_ctl_t               scan_ctl;
  logic                    found;
  logic [IDX_W-1:0]        pick;
  logic                    elig;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign ld_addr   = IDX_W'(idx_r);
  assign rd_addr   = (state_r == ST_SCAN) ? scan_addr_r : ld_addr;
  assign ram_wr    = (state_r == ST_LD_ADD);
  assign elig      = loaded_r[rd_idx_r] && !taken_r[rd_idx_r];

  assign scan_ctl.clear = in_xfer;
  assign scan_ctl.step  = rd_vld_r;

  fpfa_size_ram #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (SIZE_BITS),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (ld_addr),
    .wr_data (req_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fpfa_scan_unit #(
    .SIZE_BITS (SIZE_BITS),
    .IDX_W     (IDX_W)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (scan_ctl),
    .policy_i (policy_r),
    .req_i    (req_r),
    .size_i   (rd_data),
    .elig_i   (elig),
    .idx_i    (rd_idx_r),
    .found_o  (found),
    .pick_o   (pick)
  );

  // Sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_tuser)
            FN_REQUEST: state_nxt = ST_SCAN;
            FN_LOAD:    state_nxt = (32'(in_tdata[2:0]) < NUM_BLOCKS) ? ST_LD_RD : ST_FINISH;
            default:    state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        // advance once the last partition has been addressed
        if (cnt_r == CNT_W'(NUM_BLOCKS - 1)) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT:   state_nxt = ST_GRANT;
      ST_GRANT:  state_nxt = ST_FINISH;
      ST_LD_RD:  state_nxt = ST_LD_SUB;
      ST_LD_SUB: state_nxt = ST_LD_ADD;
      ST_LD_ADD: state_nxt = ST_FINISH;
      ST_FINISH: begin
        // hold until the result register is free
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Fit policy register; the user must write it only while idle, the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIRST;
    end else if (cfg_wr_en) begin
      policy_r <= policy_t'(cfg_wr_data);
    end
  end

  // Latch the item fields on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      idx_r      <= in_tdata[2:0];
      req_r      <= SIZE_BITS'(in_tdata[18:3]);
    end
  end

  // Scan address generation: one partition per cycle, wrapping at the table end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      scan_addr_r <= (policy_r == POL_NEXT) ? ptr_r : '0;
      cnt_r       <= '0;
    end else if (state_r == ST_SCAN) begin
      scan_addr_r <= (scan_addr_r == IDX_W'(NUM_BLOCKS - 1)) ? '0 : scan_addr_r + 1'b1;
      cnt_r       <= cnt_r + 1'b1;
    end
    rd_idx_r <= scan_addr_r;
  end

  // Table flags, pointer and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r      <= '0;
      taken_r       <= '0;
      ptr_r         <= '0;
      granted_sum_r <= '0;
      memory_sum_r  <= '0;
      granted_r     <= 1'b0;
      number_r      <= '0;
    end else begin
      if (in_xfer) begin
        granted_r <= 1'b0;
        number_r  <= '0;
        if (in_tuser == FN_CLEAR) begin
          loaded_r      <= '0;
          taken_r       <= '0;
          ptr_r         <= '0;
          granted_sum_r <= '0;
          memory_sum_r  <= '0;
        end
      end
      if (state_r == ST_GRANT && found) begin
        taken_r[pick] <= 1'b1;
        granted_sum_r <= sat_add(granted_sum_r, SUM_W'(req_r));
        if (policy_r == POL_NEXT) begin
          ptr_r <= pick;
        end
        granted_r <= 1'b1;
        number_r  <= IDX_FIELD_W'(pick);
      end
      // drop the old size of a reloaded partition
      if (state_r == ST_LD_SUB && loaded_r[ld_addr]) begin
        memory_sum_r <= sat_sub(memory_sum_r, SUM_W'(rd_data));
      end
      if (state_r == ST_LD_ADD) begin
        memory_sum_r      <= sat_add(memory_sum_r, SUM_W'(req_r));
        loaded_r[ld_addr] <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FINISH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && out_free) begin
      out_data_r <= {6'd0, memory_sum_r, granted_sum_r, number_r, granted_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // zero fill bits of the input word carry nothing
  logic unused_ok;
  assign unused_ok = ^in_tdata[IN_TDATA_W-1:19];

endmodule

// ===== design/fpfa_checker.sv =====
// Port-level checker for the fixed-partition fit allocator, bound to the top level.
module fpfa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_wr_en,
  input logic [1:0]                       cfg_wr_data,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [fpfa_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [fpfa_pkg::FUNC_W-1:0]      in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [fpfa_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // one item at a time: the block stalls after each transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[3:1] == 3'd0)
    else $error("block number set without a grant");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (.*);
